// ===== src/amap_pkg.sv =====
// address range map allocator: shared types, constants and helpers
// no dependencies; imported by every other file of the block
package amap_pkg;

	localparam int MAP_DEPTH = 128;
	localparam int ADDR_BITS = 52;
	localparam int IDX_W     = $clog2(MAP_DEPTH);
	localparam int CNT_W     = $clog2(MAP_DEPTH + 1);
	localparam int OP_W      = 3;
	localparam int ALIGN_W   = 31;
	localparam int RTYPE_W   = 5;
	localparam int TYPE_W    = 4;
	localparam int USE_W     = 3;
	localparam int FLAG_W    = 32;
	localparam int SIDX_W    = 8;
	localparam int STAT_W    = 2;
	localparam int IW        = (CNT_W > SIDX_W) ? CNT_W : SIDX_W;

	localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP = 3'd1;
	localparam logic [OP_W-1:0] OP_ALLOC  = 3'd2;
	localparam logic [OP_W-1:0] OP_FREE   = 3'd3;
	localparam logic [OP_W-1:0] OP_MATCH  = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_MISS     = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STAT_W-1:0] ST_BAD_FREE = 2'd3;

	localparam logic [RTYPE_W-1:0] TYPE_ANY  = 5'h1f;
	localparam logic [SIDX_W-1:0]  IDX_NONE  = 8'hff;

	typedef enum logic [2:0] {
		K_INSERT,
		K_LOOKUP,
		K_ALLOC,
		K_FREE,
		K_MATCH,
		K_UNKNOWN
	} op_kind_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] base;
		logic [ADDR_BITS-1:0] length;
		logic [TYPE_W-1:0]    etype;
		logic [USE_W-1:0]     euse;
		logic [FLAG_W-1:0]    flags;
	} entry_t;

	typedef struct packed {
		op_kind_t             kind;
		logic [ADDR_BITS-1:0] base;
		logic [ADDR_BITS-1:0] length;
		logic [ALIGN_W-1:0]   align;
		logic [RTYPE_W-1:0]   rtype;
		logic                 any_type;
		logic [USE_W-1:0]     ruse;
		logic [FLAG_W-1:0]    flags;
		logic [IW-1:0]        first_idx;
	} cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0]    status;
		logic [ADDR_BITS-1:0] found_base;
		logic [ADDR_BITS-1:0] found_length;
		logic [TYPE_W-1:0]    found_type;
		logic [USE_W-1:0]     found_use;
		logic [FLAG_W-1:0]    found_flags;
		logic [SIDX_W-1:0]    found_index;
	} rsp_t;

	function automatic rsp_t make_rsp(input logic [STAT_W-1:0] st, input logic hit,
			input logic [IW-1:0] idx, input entry_t e, input logic [ADDR_BITS-1:0] fb);
		rsp_t r;
		r.status = st;
		if (hit) begin
			r.found_base   = fb;
			r.found_length = e.length;
			r.found_type   = e.etype;
			r.found_use    = e.euse;
			r.found_flags  = e.flags;
			r.found_index  = SIDX_W'(idx);
		end else begin
			r.found_base   = '0;
			r.found_length = '0;
			r.found_type   = '0;
			r.found_use    = '0;
			r.found_flags  = '0;
			r.found_index  = IDX_NONE;
		end
		return r;
	endfunction

endpackage

// ===== src/amap_if.sv =====
// request and response channels of the address range map allocator
// depends on amap_pkg
interface amap_req_if;
	import amap_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      op;
	logic [ADDR_BITS-1:0] base;
	logic [ADDR_BITS-1:0] length;
	logic [ALIGN_W-1:0]   align;
	logic signed [RTYPE_W-1:0] range_type;
	logic [USE_W-1:0]     range_use;
	logic [FLAG_W-1:0]    mem_flags;
	logic signed [SIDX_W-1:0]  start_index;
	modport source(output valid, op, base, length, align, range_type, range_use, mem_flags,
		start_index, input ready);
	modport sink(input valid, op, base, length, align, range_type, range_use, mem_flags,
		start_index, output ready);
endinterface

interface amap_rsp_if;
	import amap_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [STAT_W-1:0]    status;
	logic [ADDR_BITS-1:0] found_base;
	logic [ADDR_BITS-1:0] found_length;
	logic [TYPE_W-1:0]    found_type;
	logic [USE_W-1:0]     found_use;
	logic [FLAG_W-1:0]    found_flags;
	logic signed [SIDX_W-1:0] found_index;
	modport source(output valid, status, found_base, found_length, found_type, found_use,
		found_flags, found_index, input ready);
	modport sink(input valid, status, found_base, found_length, found_type, found_use,
		found_flags, found_index, output ready);
endinterface

// ===== src/address_range_map_allocator_core.sv =====
// top level of the address range map allocator: front end, command queue, back end
// depends on amap_pkg, amap_if, amap_front and amap_back
//
//  channel | dir | transfer when       | payload
//  req     | in  | req.valid&req.ready | op, base, length, align, range_type, range_use,
//          |     |                     | mem_flags, start_index
//  rsp     | out | rsp.valid&rsp.ready | status, found_* fields, one per request
//
// lookup and free: binary search, plus merge copies on free
// allocate and match: linear scan over the table entries
// insert, splits and merges move entries one at a time through the table memory
// a nonzero alignment takes a 52-step bit-serial remainder per candidate
// arst_n empties the table and queue; the table memory itself needs no clearing
// requests queue (two deep) while the back end works or the response waits
module address_range_map_allocator_core (
	input  logic        clk,
	input  logic        arst_n,
	amap_req_if.sink    req,
	amap_rsp_if.source  rsp
);
	import amap_pkg::*;

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	amap_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	amap_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp       (rsp)
	);

	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
		else $error("queued command lost while back end busy");

	a_full_queue: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> cmd_valid)
		else $error("front refuses requests with empty queue");

	a_ok_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_OK |-> !rsp.found_index[SIDX_W-1])
		else $error("ok response without an entry index");

	a_miss_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_OK |-> rsp.found_index == IDX_NONE)
		else $error("error response carries an entry index");

endmodule

// ===== src/amap_front.sv =====
// front end: takes request transfers, decodes the operation, two-entry command queue
// depends on amap_pkg and amap_if
module amap_front (
	input  logic            clk,
	input  logic            arst_n,
	amap_req_if.sink        req,
	output logic            cmd_valid,
	input  logic            cmd_ready,
	output amap_pkg::cmd_t  cmd
);
	import amap_pkg::*;

	cmd_t       fifo_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;
	cmd_t       dec;

	always_comb begin
		dec.base      = req.base;
		dec.length    = req.length;
		dec.align     = req.align;
		dec.rtype     = req.range_type;
		dec.any_type  = (req.range_type == TYPE_ANY);
		dec.ruse      = req.range_use;
		dec.flags     = req.mem_flags;
		// negative start clamps to the first entry
		dec.first_idx = req.start_index[SIDX_W-1] ? '0 :
			IW'(req.start_index[SIDX_W-2:0]) + IW'(1);
		case (req.op)
			OP_INSERT: dec.kind = K_INSERT;
			OP_LOOKUP: dec.kind = K_LOOKUP;
			OP_ALLOC:  dec.kind = K_ALLOC;
			OP_FREE:   dec.kind = K_FREE;
			OP_MATCH:  dec.kind = K_MATCH;
			default:   dec.kind = K_UNKNOWN;
		endcase
	end

	assign req.ready = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rp_q];
	assign push      = req.valid && req.ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== src/amap_back.sv =====
// back end: sorted range table in a 1R1W memory, operation sequencer,
// alignment divider and response register; depends on amap_pkg and amap_if
module amap_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  amap_pkg::cmd_t  cmd,
	amap_rsp_if.source      rsp
);
	import amap_pkg::*;

	localparam int NST = 29;
	localparam int DC_W = $clog2(ADDR_BITS);

	typedef enum logic [NST-1:0] {
		S_IDLE     = NST'(1) << 0,
		S_RD       = NST'(1) << 1,
		S_OUT      = NST'(1) << 2,
		S_INS_CHK  = NST'(1) << 3,
		S_INS_CMP  = NST'(1) << 4,
		S_INS_PUT  = NST'(1) << 5,
		S_BS       = NST'(1) << 6,
		S_BS_CMP   = NST'(1) << 7,
		S_FR_PREV  = NST'(1) << 8,
		S_FR_PCMP  = NST'(1) << 9,
		S_FR_NEXT  = NST'(1) << 10,
		S_FR_NCMP  = NST'(1) << 11,
		S_FR_DONE  = NST'(1) << 12,
		S_DROP     = NST'(1) << 13,
		S_DROP_W   = NST'(1) << 14,
		S_OPEN     = NST'(1) << 15,
		S_OPEN_W   = NST'(1) << 16,
		S_AL_NEXT  = NST'(1) << 17,
		S_AL_CHK   = NST'(1) << 18,
		S_AL_FRONT = NST'(1) << 19,
		S_AL_FRNT2 = NST'(1) << 20,
		S_AL_DIV   = NST'(1) << 21,
		S_AL_STEP  = NST'(1) << 22,
		S_AL_SLOP  = NST'(1) << 23,
		S_AL_FIT   = NST'(1) << 24,
		S_AL_SPLIT = NST'(1) << 25,
		S_AL_SPL2  = NST'(1) << 26,
		S_MT_NEXT  = NST'(1) << 27,
		S_MT_CHK   = NST'(1) << 28
	} state_t;

	entry_t mem_q [MAP_DEPTH];
	entry_t rd_q;
	logic [IDX_W-1:0] ra_q;
	logic             we;
	logic [IDX_W-1:0] wa;
	entry_t           wd;

	state_t state_q, nxt_q, ret_q;
	cmd_t   c_q;
	entry_t cur_q;
	rsp_t   res_q, out_q;
	logic   out_valid_q;
	logic   out_load;
	logic [CNT_W-1:0] count_q;
	logic [IW-1:0]    i_q, k_q, m_q, lo_q, n_q;
	logic [ADDR_BITS-1:0] x_q, xs_q, slop_q;
	logic [ALIGN_W-1:0]   rem_q;
	logic [DC_W-1:0]      dcnt_q;

	logic [IW-1:0] cnt_x, bs_h, bs_m;
	logic          full;
	logic          bs_le, bs_fit;
	logic          pm_ok, nm_ok;
	logic          al_type_ok, al_range_bad;
	logic [ADDR_BITS-1:0] want_end, have_end, adj, front_l;
	logic [ALIGN_W:0]     trial;
	logic          trial_ge;
	entry_t        new_e, freed_e, pmerge_e, nmerge_e, take_e, split_lo_e, split_hi_e;
	entry_t        front_lo_e, front_hi_e;

	assign cnt_x   = IW'(count_q);
	assign full    = (count_q >= CNT_W'(MAP_DEPTH));
	assign bs_h    = n_q >> 1;
	assign bs_m    = lo_q + bs_h;
	assign bs_le   = (rd_q.base <= c_q.base);
	assign bs_fit  = (ADDR_BITS'(c_q.base + c_q.length - rd_q.base) <= rd_q.length);
	assign pm_ok   = (rd_q.etype == cur_q.etype) && (rd_q.euse == cur_q.euse) &&
		(ADDR_BITS'(rd_q.base + rd_q.length) == cur_q.base);
	assign nm_ok   = (rd_q.etype == cur_q.etype) && (rd_q.euse == cur_q.euse) &&
		(ADDR_BITS'(cur_q.base + cur_q.length) == rd_q.base);
	assign al_type_ok = (c_q.any_type || ({1'b0, rd_q.etype} == c_q.rtype)) &&
		(rd_q.euse == '0);
	assign want_end = c_q.base + c_q.length;
	assign have_end = rd_q.base + rd_q.length;
	assign al_range_bad = (want_end > have_end) || (c_q.base < rd_q.base);
	assign adj      = c_q.length + slop_q;
	assign front_l  = c_q.base - cur_q.base;
	assign trial    = {rem_q, xs_q[ADDR_BITS-1]};
	assign trial_ge = (trial >= {1'b0, c_q.align});
	assign out_load = (state_q == S_OUT) && (!out_valid_q || rsp.ready);

	always_comb begin
		new_e       = '{base: c_q.base, length: c_q.length, etype: c_q.rtype[TYPE_W-1:0],
			euse: c_q.ruse, flags: c_q.flags};
		freed_e     = rd_q;
		freed_e.euse  = '0;
		freed_e.flags = '0;
		pmerge_e    = rd_q;
		pmerge_e.length = rd_q.length + cur_q.length;
		nmerge_e    = cur_q;
		nmerge_e.length = cur_q.length + rd_q.length;
		take_e      = cur_q;
		take_e.euse  = c_q.ruse;
		take_e.flags = c_q.flags;
		split_lo_e  = take_e;
		split_lo_e.length = adj;
		split_hi_e  = cur_q;
		split_hi_e.base   = cur_q.base + adj;
		split_hi_e.length = cur_q.length - adj;
		front_lo_e  = cur_q;
		front_lo_e.length = front_l;
		front_hi_e  = cur_q;
		front_hi_e.base   = cur_q.base + front_l;
		front_hi_e.length = cur_q.length - front_l;
	end

	// table write port
	always_comb begin
		we = 1'b0;
		wa = i_q[IDX_W-1:0];
		wd = cur_q;
		case (state_q)
			S_INS_CMP: begin
				we = (rd_q.base >= c_q.base);
				wd = rd_q;
			end
			S_INS_PUT: begin
				we = 1'b1;
				wd = new_e;
			end
			S_BS_CMP: begin
				we = (c_q.kind == K_FREE) && bs_le && bs_fit && (rd_q.euse != '0);
				wa = m_q[IDX_W-1:0];
				wd = freed_e;
			end
			S_FR_PCMP: begin
				we = pm_ok;
				wa = IDX_W'(m_q - IW'(1));
				wd = pmerge_e;
			end
			S_FR_NCMP: begin
				we = nm_ok;
				wa = m_q[IDX_W-1:0];
				wd = nmerge_e;
			end
			S_DROP_W, S_OPEN_W: begin
				we = 1'b1;
				wa = k_q[IDX_W-1:0];
				wd = rd_q;
			end
			S_AL_FRONT: begin
				we = 1'b1;
				wd = front_lo_e;
			end
			S_AL_FRNT2: begin
				we = 1'b1;
				wa = IDX_W'(i_q + IW'(1));
				wd = front_hi_e;
			end
			S_AL_FIT: begin
				we = (cur_q.length == adj);
				wd = take_e;
			end
			S_AL_SPLIT: begin
				we = 1'b1;
				wd = split_lo_e;
			end
			S_AL_SPL2: begin
				we = 1'b1;
				wa = IDX_W'(i_q + IW'(1));
				wd = split_hi_e;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		rd_q <= mem_q[ra_q];
	end

	assign cmd_ready = (state_q == S_IDLE);

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_q.status;
	assign rsp.found_base   = out_q.found_base;
	assign rsp.found_length = out_q.found_length;
	assign rsp.found_type   = out_q.found_type;
	assign rsp.found_use    = out_q.found_use;
	assign rsp.found_flags  = out_q.found_flags;
	assign rsp.found_index  = out_q.found_index;

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				c_q  <= cmd;
				lo_q <= '0;
				n_q  <= cnt_x;
				i_q  <= (cmd.kind == K_INSERT) ? cnt_x :
					(cmd.kind == K_MATCH) ? cmd.first_idx : '0;
				res_q <= make_rsp((cmd.kind == K_INSERT && full) ? ST_FULL : ST_MISS, 1'b0,
					'0, cur_q, '0);
			end
			S_OUT: begin
				if (out_load) begin
					out_q <= res_q;
				end
			end
			S_INS_CHK: begin
				ra_q <= IDX_W'(i_q - IW'(1));
				nxt_q <= S_INS_CMP;
			end
			S_INS_CMP: begin
				if (rd_q.base >= c_q.base) begin
					i_q <= i_q - IW'(1);
				end
			end
			S_INS_PUT: begin
				res_q <= make_rsp(ST_OK, 1'b1, i_q, new_e, c_q.base);
			end
			S_BS: begin
				m_q  <= bs_m;
				ra_q <= bs_m[IDX_W-1:0];
				nxt_q <= S_BS_CMP;
				res_q <= make_rsp((c_q.kind == K_FREE) ? ST_BAD_FREE : ST_MISS, 1'b0, '0,
					cur_q, '0);
			end
			S_BS_CMP: begin
				if (bs_le) begin
					if (bs_fit) begin
						cur_q <= (c_q.kind == K_FREE) ? freed_e : rd_q;
						res_q <= (c_q.kind == K_FREE && rd_q.euse == '0) ?
							make_rsp(ST_BAD_FREE, 1'b0, '0, rd_q, '0) :
							make_rsp(ST_OK, 1'b1, m_q, rd_q, rd_q.base);
					end else begin
						lo_q <= m_q + IW'(1);
						n_q  <= n_q - bs_h - IW'(1);
					end
				end else begin
					n_q <= bs_h;
				end
			end
			S_FR_PREV: begin
				ra_q <= IDX_W'(m_q - IW'(1));
				nxt_q <= S_FR_PCMP;
			end
			S_FR_PCMP: begin
				if (pm_ok) begin
					cur_q <= pmerge_e;
					m_q   <= m_q - IW'(1);
					k_q   <= m_q;
					ret_q <= S_FR_NEXT;
				end
			end
			S_FR_NEXT: begin
				ra_q <= IDX_W'(m_q + IW'(1));
				nxt_q <= S_FR_NCMP;
				res_q <= make_rsp(ST_OK, 1'b1, m_q, cur_q, cur_q.base);
			end
			S_FR_NCMP: begin
				if (nm_ok) begin
					cur_q <= nmerge_e;
					k_q   <= m_q + IW'(1);
					ret_q <= S_FR_DONE;
				end
			end
			S_FR_DONE: begin
				res_q <= make_rsp(ST_OK, 1'b1, m_q, cur_q, cur_q.base);
			end
			S_DROP: begin
				ra_q <= IDX_W'(k_q + IW'(1));
				nxt_q <= S_DROP_W;
			end
			S_DROP_W: begin
				k_q <= k_q + IW'(1);
			end
			S_OPEN: begin
				ra_q <= IDX_W'(k_q - IW'(1));
				nxt_q <= S_OPEN_W;
			end
			S_OPEN_W: begin
				k_q <= k_q - IW'(1);
			end
			S_AL_NEXT, S_MT_NEXT: begin
				ra_q <= i_q[IDX_W-1:0];
				nxt_q <= (state_q == S_AL_NEXT) ? S_AL_CHK : S_MT_CHK;
				res_q <= make_rsp(ST_MISS, 1'b0, '0, cur_q, '0);
			end
			S_AL_CHK: begin
				cur_q <= rd_q;
				k_q   <= cnt_x;
				ret_q <= S_AL_FRONT;
				if (!al_type_ok || (c_q.base != '0 && al_range_bad)) begin
					i_q <= i_q + IW'(1);
				end
				res_q <= make_rsp(ST_FULL, 1'b0, '0, cur_q, '0);
			end
			S_AL_FRNT2: begin
				i_q <= i_q + IW'(1);
			end
			S_AL_DIV: begin
				x_q    <= cur_q.base + ADDR_BITS'(c_q.align) - ADDR_BITS'(1);
				xs_q   <= cur_q.base + ADDR_BITS'(c_q.align) - ADDR_BITS'(1);
				rem_q  <= '0;
				dcnt_q <= '0;
				slop_q <= '0;
			end
			S_AL_STEP: begin
				rem_q  <= trial_ge ? ALIGN_W'(trial - {1'b0, c_q.align}) : trial[ALIGN_W-1:0];
				xs_q   <= xs_q << 1;
				dcnt_q <= dcnt_q + DC_W'(1);
			end
			S_AL_SLOP: begin
				slop_q <= x_q - ADDR_BITS'(rem_q) - cur_q.base;
			end
			S_AL_FIT: begin
				k_q   <= cnt_x;
				ret_q <= S_AL_SPLIT;
				if (cur_q.length < adj) begin
					i_q <= i_q + IW'(1);
				end
				if (cur_q.length > adj && full) begin
					res_q <= make_rsp(ST_FULL, 1'b0, '0, cur_q, '0);
				end else begin
					res_q <= make_rsp(ST_OK, 1'b1, i_q, split_lo_e, cur_q.base + slop_q);
				end
			end
			S_MT_CHK: begin
				if (({1'b0, rd_q.etype} == c_q.rtype) && (rd_q.euse == c_q.ruse)) begin
					res_q <= make_rsp(ST_OK, 1'b1, i_q, rd_q, rd_q.base);
				end else begin
					i_q <= i_q + IW'(1);
				end
			end
			default: begin
				dcnt_q <= dcnt_q;
			end
		endcase
	end

	// control: sequencer state, entry count and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						case (cmd.kind)
							K_INSERT: state_q <= full ? S_OUT : S_INS_CHK;
							K_LOOKUP, K_FREE: state_q <= S_BS;
							K_ALLOC: state_q <= S_AL_NEXT;
							K_MATCH: state_q <= S_MT_NEXT;
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_RD: state_q <= nxt_q;
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				S_INS_CHK: state_q <= (i_q != '0) ? S_RD : S_INS_PUT;
				S_INS_CMP: state_q <= (rd_q.base >= c_q.base) ? S_INS_CHK : S_INS_PUT;
				S_INS_PUT: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_OUT;
				end
				S_BS: state_q <= (n_q == '0) ? S_OUT : S_RD;
				S_BS_CMP: begin
					if (bs_le && bs_fit) begin
						state_q <= (c_q.kind == K_FREE && rd_q.euse != '0) ? S_FR_PREV : S_OUT;
					end else begin
						state_q <= S_BS;
					end
				end
				S_FR_PREV: state_q <= (m_q != '0) ? S_RD : S_FR_NEXT;
				S_FR_PCMP: state_q <= pm_ok ? S_DROP : S_FR_NEXT;
				S_FR_NEXT: state_q <= ((m_q + IW'(1)) < cnt_x) ? S_RD : S_OUT;
				S_FR_NCMP: state_q <= nm_ok ? S_DROP : S_OUT;
				S_FR_DONE: state_q <= S_OUT;
				S_DROP: begin
					if ((k_q + IW'(1)) < cnt_x) begin
						state_q <= S_RD;
					end else begin
						count_q <= count_q - CNT_W'(1);
						state_q <= ret_q;
					end
				end
				S_DROP_W: state_q <= S_DROP;
				S_OPEN: begin
					if (k_q > i_q) begin
						state_q <= S_RD;
					end else begin
						count_q <= count_q + CNT_W'(1);
						state_q <= ret_q;
					end
				end
				S_OPEN_W: state_q <= S_OPEN;
				S_AL_NEXT, S_MT_NEXT: state_q <= (i_q < cnt_x) ? S_RD : S_OUT;
				S_AL_CHK: begin
					if (!al_type_ok || (c_q.base != '0 && al_range_bad)) begin
						state_q <= S_AL_NEXT;
					end else if (c_q.base != '0 && rd_q.base < c_q.base) begin
						state_q <= full ? S_OUT : S_OPEN;
					end else begin
						state_q <= S_AL_DIV;
					end
				end
				S_AL_FRONT: state_q <= S_AL_FRNT2;
				S_AL_FRNT2: state_q <= S_AL_NEXT;
				S_AL_DIV: state_q <= (c_q.align == '0) ? S_AL_FIT : S_AL_STEP;
				S_AL_STEP: state_q <= (dcnt_q == DC_W'(ADDR_BITS - 1)) ? S_AL_SLOP : S_AL_STEP;
				S_AL_SLOP: state_q <= S_AL_FIT;
				S_AL_FIT: begin
					if (cur_q.length < adj) begin
						state_q <= S_AL_NEXT;
					end else if (cur_q.length > adj) begin
						state_q <= full ? S_OUT : S_OPEN;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_AL_SPLIT: state_q <= S_AL_SPL2;
				S_AL_SPL2: state_q <= S_OUT;
				S_MT_CHK: begin
					if (({1'b0, rd_q.etype} == c_q.rtype) && (rd_q.euse == c_q.ruse)) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_MT_NEXT;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
